[rtl/core/llx_pkg.sv]
// llx_pkg: shared types, constants and helpers for the lua line lexer
// holds beat structs, controller/datapath command and status, keyword table
// no dependencies; used by llx_ctrl, llx_dpath and lua_syntax_highlight_lexer
package llx_pkg;

    // identifier buffer sizing
    localparam int MAX_KEYWORD_LEN = 8;
    localparam int IDX_W           = $clog2(MAX_KEYWORD_LEN);
    localparam int CNT_W           = $clog2(MAX_KEYWORD_LEN + 1);

    // keyword table: text right-justified, one byte per char
    localparam int NUM_KEYWORDS = 21;
    localparam int KW_CHARS     = 8;
    localparam int KW_BITS      = KW_CHARS * 8;

    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "if", "then", "else", "elseif", "end", "for", "while", "do",
        "function", "return", "local", "and", "or", "not", "nil", "true",
        "false", "repeat", "until", "break", "in"
    };
    localparam int KW_LEN [NUM_KEYWORDS] = '{
        2, 4, 4, 6, 3, 3, 5, 2, 8, 6, 5, 3, 2, 3, 3, 4, 5, 6, 5, 5, 2
    };

    // character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // attribute codes
    localparam logic [1:0] ATTR_PLAIN   = 2'd0;
    localparam logic [1:0] ATTR_HILITE  = 2'd1;
    localparam logic [1:0] ATTR_KEYWORD = 2'd2;

    typedef logic [MAX_KEYWORD_LEN-1:0][7:0] t_ident_buf;
    typedef logic [CNT_W-1:0]                t_cnt;
    typedef logic [IDX_W-1:0]                t_idx;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] attr;
        logic       out_line_end;
        logic       run_last;
    } t_out_beat;

    // result phases of one item, in emit order
    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH_A,
        S_DASH_A,
        S_CHAR,
        S_FLUSH_B,
        S_DASH_B
    } t_state;

    typedef enum logic [1:0] {
        SRC_FLUSH,
        SRC_DASH_A,
        SRC_CHAR,
        SRC_DASH_B
    } t_src;

    // what one accepted item has to emit
    typedef struct packed {
        logic       flush_a;
        logic       dash_a;
        logic [1:0] dash_a_attr;
        logic       char_en;
        logic [1:0] char_attr;
        logic       flush_b;
        logic       dash_b;
        logic       flush_plain;
        t_cnt       flush_len;
    } t_plan;

    typedef struct packed {
        logic ready;
        logic accept;
        logic emit;
        t_src src;
        logic flush_step;
        logic run_last;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        logic  out_free;
        logic  flush_done;
        t_plan plan;
        t_plan plan_n;
    } t_status;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9");
    endfunction

    // keyword test over the first n buffered chars
    function automatic logic kw_hit(t_ident_buf b, t_cnt n);
        logic hit;
        logic eq;
        hit = 1'b0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            eq = (KW_LEN[k] == int'(n));
            for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
                if (i < KW_LEN[k]) begin
                    if (b[i] != KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8]) begin
                        eq = 1'b0;
                    end
                end
            end
            hit = hit | eq;
        end
        return hit;
    endfunction

    // next enabled phase strictly after s, or idle
    function automatic t_state next_after(t_plan p, t_state s);
        t_state r;
        r = S_IDLE;
        if (s < S_DASH_B  && p.dash_b)  r = S_DASH_B;
        if (s < S_FLUSH_B && p.flush_b) r = S_FLUSH_B;
        if (s < S_CHAR    && p.char_en) r = S_CHAR;
        if (s < S_DASH_A  && p.dash_a)  r = S_DASH_A;
        if (s < S_FLUSH_A && p.flush_a) r = S_FLUSH_A;
        return r;
    endfunction

endpackage

[rtl/core/lua_syntax_highlight_lexer.sv]
// lua_syntax_highlight_lexer: top level of the streaming lua line lexer
// instantiates llx_ctrl (result sequencer) and llx_dpath (lexer datapath)
// depends on llx_pkg
//
// Takes one byte of a text line per input beat, with line_end on the last
// byte, and returns every byte in order tagged plain, highlighted (string or
// comment) or keyword. Identifiers are held until they end and a single dash
// is held for one byte, so one input beat yields zero to MAX_KEYWORD_LEN + 1
// result beats; run_last marks the last of them and out_line_end the last
// result of a line. An input beat is taken only while the sequencer is idle:
// a byte that gives no result leaves it idle, and after one that gives results
// the sequencer puts out one result beat per cycle into the output register,
// waiting there while i_out_stall is held by the receiver, and then goes idle.
// A finished result may still wait in the output
// register while the next byte is taken. No clearing pass is needed after
// reset.
module lua_syntax_highlight_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  llx_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output llx_pkg::t_out_beat o_out_beat
);

    llx_pkg::t_cmd    cmd;
    llx_pkg::t_status status;

    assign o_in_stall = !cmd.ready;

    // result sequencer
    llx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // lexer datapath
    llx_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

[rtl/core/llx_ctrl.sv]
// llx_ctrl: result sequencer for the lua line lexer
// walks the phases of one item's plan and issues emit commands
// depends on llx_pkg
module llx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  llx_pkg::t_status i_status,
    output llx_pkg::t_cmd    o_cmd
);

    llx_pkg::t_state r_state;
    llx_pkg::t_state n_state;
    llx_pkg::t_state after_cur;

    assign after_cur = llx_pkg::next_after(i_status.plan, r_state);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llx_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            llx_pkg::S_IDLE: begin
                if (i_status.in_valid) begin
                    n_state = llx_pkg::next_after(i_status.plan_n, llx_pkg::S_IDLE);
                end
            end
            llx_pkg::S_FLUSH_A, llx_pkg::S_FLUSH_B: begin
                if (i_status.out_free && i_status.flush_done) begin
                    n_state = after_cur;
                end
            end
            llx_pkg::S_DASH_A, llx_pkg::S_CHAR, llx_pkg::S_DASH_B: begin
                if (i_status.out_free) begin
                    n_state = after_cur;
                end
            end
            default: n_state = llx_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.src        = llx_pkg::SRC_CHAR;
        case (r_state)
            llx_pkg::S_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_status.in_valid;
            end
            llx_pkg::S_FLUSH_A, llx_pkg::S_FLUSH_B: begin
                o_cmd.src        = llx_pkg::SRC_FLUSH;
                o_cmd.emit       = i_status.out_free;
                o_cmd.flush_step = i_status.out_free;
                o_cmd.run_last   = i_status.flush_done && (after_cur == llx_pkg::S_IDLE);
            end
            llx_pkg::S_DASH_A: begin
                o_cmd.src      = llx_pkg::SRC_DASH_A;
                o_cmd.emit     = i_status.out_free;
                o_cmd.run_last = (after_cur == llx_pkg::S_IDLE);
            end
            llx_pkg::S_CHAR: begin
                o_cmd.src      = llx_pkg::SRC_CHAR;
                o_cmd.emit     = i_status.out_free;
                o_cmd.run_last = (after_cur == llx_pkg::S_IDLE);
            end
            llx_pkg::S_DASH_B: begin
                o_cmd.src      = llx_pkg::SRC_DASH_B;
                o_cmd.emit     = i_status.out_free;
                o_cmd.run_last = (after_cur == llx_pkg::S_IDLE);
            end
            default: o_cmd.ready = 1'b0;
        endcase
    end

endmodule

[rtl/core/llx_dpath.sv]
// llx_dpath: lexer state, identifier buffer, item plan and output register
// decides each item's results at accept and forms beats on command
// depends on llx_pkg
module llx_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  llx_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output llx_pkg::t_out_beat o_out_beat,
    input  llx_pkg::t_cmd      i_cmd,
    output llx_pkg::t_status   o_status
);

    // lexer state
    logic                r_in_quote,   n_in_quote;
    logic [7:0]          r_quote_char, n_quote_char;
    logic                r_in_comment, n_in_comment;
    logic [7:0]          r_prev_char,  n_prev_char;
    logic                r_dash,       n_dash;
    llx_pkg::t_ident_buf r_buf,        n_buf;
    llx_pkg::t_cnt       r_count,      n_count;
    logic                r_too_long,   n_too_long;

    // item being sequenced
    llx_pkg::t_plan      r_plan,       n_plan;
    logic [7:0]          r_ch;
    logic                r_last;
    llx_pkg::t_idx       r_flush_idx;

    // output register
    logic                r_out_valid;
    llx_pkg::t_out_beat  r_out;
    llx_pkg::t_out_beat  n_out;

    logic [7:0] ch;
    logic       active;
    logic       dash_done;
    logic       out_free;
    logic       flush_done;
    logic       kw;

    assign ch       = i_in_beat.char_in;
    assign active   = (r_count != '0) || r_too_long;
    assign out_free = !r_out_valid || !i_out_stall;
    assign flush_done =
        ((llx_pkg::CNT_W)'(r_flush_idx) + (llx_pkg::CNT_W)'(1)) == r_plan.flush_len;
    assign kw = llx_pkg::kw_hit(r_buf, r_plan.flush_len);

    // decide the item: state update and result plan
    always_comb begin
        n_in_quote   = r_in_quote;
        n_quote_char = r_quote_char;
        n_in_comment = r_in_comment;
        n_dash       = r_dash;
        n_buf        = r_buf;
        n_count      = r_count;
        n_too_long   = r_too_long;
        n_plan       = '0;
        dash_done    = 1'b0;

        if (r_in_comment) begin
            n_plan.char_en   = 1'b1;
            n_plan.char_attr = llx_pkg::ATTR_HILITE;
        end else if (r_in_quote) begin
            n_plan.char_en   = 1'b1;
            n_plan.char_attr = llx_pkg::ATTR_HILITE;
            if (ch == r_quote_char && r_prev_char != llx_pkg::CH_BSLASH) begin
                n_in_quote = 1'b0;
            end
        end else if (active && llx_pkg::is_word(ch)) begin
            if (r_too_long) begin
                n_plan.char_en   = 1'b1;
                n_plan.char_attr = llx_pkg::ATTR_PLAIN;
            end else if (r_count < (llx_pkg::CNT_W)'(llx_pkg::MAX_KEYWORD_LEN)) begin
                n_buf[r_count[llx_pkg::IDX_W-1:0]] = ch;
                n_count = r_count + (llx_pkg::CNT_W)'(1);
            end else begin
                // overlong: held chars go out plain, then this one
                n_plan.flush_a     = 1'b1;
                n_plan.flush_plain = 1'b1;
                n_plan.flush_len   = r_count;
                n_count            = '0;
                n_too_long         = 1'b1;
                n_plan.char_en     = 1'b1;
                n_plan.char_attr   = llx_pkg::ATTR_PLAIN;
            end
        end else begin
            // word ends here
            if (active) begin
                n_plan.flush_a     = (r_count != '0);
                n_plan.flush_plain = r_too_long;
                n_plan.flush_len   = r_count;
                n_count            = '0;
                n_too_long         = 1'b0;
            end
            // held dash resolves
            if (r_dash) begin
                n_dash        = 1'b0;
                n_plan.dash_a = 1'b1;
                if (ch == llx_pkg::CH_DASH) begin
                    n_plan.dash_a_attr = llx_pkg::ATTR_HILITE;
                    n_plan.char_en     = 1'b1;
                    n_plan.char_attr   = llx_pkg::ATTR_HILITE;
                    n_in_comment       = 1'b1;
                    dash_done          = 1'b1;
                end else begin
                    n_plan.dash_a_attr = llx_pkg::ATTR_PLAIN;
                end
            end
            if (!dash_done) begin
                if (ch == llx_pkg::CH_DASH) begin
                    n_dash = 1'b1;
                end else if (ch == llx_pkg::CH_DQUOTE || ch == llx_pkg::CH_SQUOTE) begin
                    n_in_quote       = 1'b1;
                    n_quote_char     = ch;
                    n_plan.char_en   = 1'b1;
                    n_plan.char_attr = llx_pkg::ATTR_HILITE;
                end else if (llx_pkg::is_letter(ch)) begin
                    n_buf[0] = ch;
                    n_count  = (llx_pkg::CNT_W)'(1);
                end else begin
                    n_plan.char_en   = 1'b1;
                    n_plan.char_attr = llx_pkg::ATTR_PLAIN;
                end
            end
        end

        n_prev_char = ch;

        // line end: flush what is held, then clear the line state
        if (i_in_beat.line_end) begin
            // an overlong word has nothing left to flush, keep the first flush length
            if (n_count != '0) begin
                n_plan.flush_b     = 1'b1;
                n_plan.flush_plain = n_too_long;
                n_plan.flush_len   = n_count;
            end
            n_plan.dash_b = n_dash;
            n_in_quote    = 1'b0;
            n_quote_char  = '0;
            n_in_comment  = 1'b0;
            n_prev_char   = '0;
            n_dash        = 1'b0;
            n_count       = '0;
            n_too_long    = 1'b0;
        end
    end

    // lexer control state and plan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote   <= 1'b0;
            r_quote_char <= '0;
            r_in_comment <= 1'b0;
            r_prev_char  <= '0;
            r_dash       <= 1'b0;
            r_count      <= '0;
            r_too_long   <= 1'b0;
            r_plan       <= '0;
            r_flush_idx  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_in_quote   <= n_in_quote;
                r_quote_char <= n_quote_char;
                r_in_comment <= n_in_comment;
                r_prev_char  <= n_prev_char;
                r_dash       <= n_dash;
                r_count      <= n_count;
                r_too_long   <= n_too_long;
                r_plan       <= n_plan;
                r_flush_idx  <= '0;
            end else if (i_cmd.flush_step) begin
                r_flush_idx  <= r_flush_idx + (llx_pkg::IDX_W)'(1);
            end
        end
    end

    // payload held for the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_buf  <= n_buf;
            r_ch   <= ch;
            r_last <= i_in_beat.line_end;
        end
    end

    // beat formation
    always_comb begin
        n_out              = '0;
        n_out.run_last     = i_cmd.run_last;
        n_out.out_line_end = i_cmd.run_last && r_last;
        case (i_cmd.src)
            llx_pkg::SRC_FLUSH: begin
                n_out.char_out = r_buf[r_flush_idx];
                n_out.attr     = (!r_plan.flush_plain && kw) ? llx_pkg::ATTR_KEYWORD
                                                             : llx_pkg::ATTR_PLAIN;
            end
            llx_pkg::SRC_DASH_A: begin
                n_out.char_out = llx_pkg::CH_DASH;
                n_out.attr     = r_plan.dash_a_attr;
            end
            llx_pkg::SRC_CHAR: begin
                n_out.char_out = r_ch;
                n_out.attr     = r_plan.char_attr;
            end
            llx_pkg::SRC_DASH_B: begin
                n_out.char_out = llx_pkg::CH_DASH;
                n_out.attr     = llx_pkg::ATTR_PLAIN;
            end
            default: n_out.char_out = r_ch;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // status to the sequencer
    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in_valid;
        o_status.out_free   = out_free;
        o_status.flush_done = flush_done;
        o_status.plan       = r_plan;
        o_status.plan_n     = n_plan;
    end

endmodule
